// ===== rtl/rsq_pkg.sv =====
// rsq_pkg: shared widths, constants and the stage payload type for the
// rounded 64-bit square root pipeline. No dependencies.
`timescale 1ns / 1ps

package rsq_pkg;

  localparam int unsigned ValueW   = 64;
  localparam int unsigned RootW    = 32;
  localparam int unsigned RemW     = 34;
  localparam int unsigned ShiftW   = 5;
  localparam int unsigned NumSteps = ValueW / 2;
  // digit steps, then round/saturate stage, then shift/output stage
  localparam int unsigned Latency  = NumSteps + 2;

  localparam logic [RootW-1:0] QuirkRoot = 32'h0001_0000;
  localparam logic [RootW-1:0] QuirkFix  = 32'h0000_FFFF;
  localparam logic [RootW-1:0] SatRoot   = 32'hFFFF_FFFF;

  // register index as decoded from paddr[2]
  localparam logic RegShiftAmount = 1'b0;

  typedef struct packed {
    logic [ValueW-1:0] rad;    // radicand, next digit pair at the top
    logic [RemW-1:0]   rem;    // partial remainder
    logic [RootW-1:0]  root;   // partial root
    logic              narrow; // operand below 2^32
    logic              last;
  } rsq_stage_t;

endpackage

// ===== rtl/rsq_step.sv =====
// rsq_step: one registered digit step of the square root recurrence.
// Depends on rsq_pkg for the stage payload type.
`timescale 1ns / 1ps

module rsq_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  rsq_pkg::rsq_stage_t d_i,
  output logic               vld_o,
  output rsq_pkg::rsq_stage_t q_o
);
  import rsq_pkg::*;

  logic               vld_q;
  rsq_stage_t         data_d, data_q;
  logic [RemW+1:0]    rem_ext;
  logic [RemW+1:0]    trial;
  logic [RemW+1:0]    diff;
  logic               ge;

  always_comb begin
    rem_ext = {d_i.rem, d_i.rad[ValueW-1 -: 2]};
    trial   = {2'b00, d_i.root, 2'b01};
    diff    = rem_ext - trial;
    ge      = (rem_ext >= trial);
    data_d       = d_i;
    data_d.rad   = {d_i.rad[ValueW-3:0], 2'b00};
    data_d.rem   = ge ? diff[RemW-1:0] : rem_ext[RemW-1:0];
    data_d.root  = {d_i.root[RootW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign vld_o = vld_q;
  assign q_o   = data_q;

endmodule

// ===== rtl/rsq_round.sv =====
// rsq_round: rounding, saturation and the small-operand fix, then the
// configured right shift into the output register. Depends on rsq_pkg.
`timescale 1ns / 1ps

module rsq_round (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        vld_i,
  input  rsq_pkg::rsq_stage_t         d_i,
  input  logic [rsq_pkg::ShiftW-1:0]  shift_i,
  output logic                        done_o,
  output logic [rsq_pkg::RootW-1:0]   root_o,
  output logic                        last_o
);
  import rsq_pkg::*;

  logic [RootW:0]   rnd;
  logic [RootW-1:0] fix_d, fix_q;
  logic             fvld_q, flast_q;
  logic             ovld_q, olast_q;
  logic [RootW-1:0] root_q;

  always_comb begin
    // round up when remainder exceeds the floor root
    rnd = {1'b0, d_i.root} + {{RootW{1'b0}}, (d_i.rem > {2'b00, d_i.root})};
    if (rnd[RootW]) begin
      fix_d = SatRoot;
    end else if (d_i.narrow && rnd[RootW-1:0] == QuirkRoot) begin
      fix_d = QuirkFix;
    end else begin
      fix_d = rnd[RootW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fvld_q <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      fvld_q <= vld_i;
      ovld_q <= fvld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    fix_q   <= fix_d;
    flast_q <= d_i.last;
    root_q  <= fix_q >> shift_i;
    olast_q <= flast_q;
  end

  assign done_o = ovld_q;
  assign root_o = root_q;
  assign last_o = olast_q;

endmodule

// ===== rtl/rounded_sqrt_u64_shift.sv =====
// rounded_sqrt_u64_shift: top level, APB register and the digit pipeline.
// Depends on rsq_pkg, rsq_step and rsq_round.
`timescale 1ns / 1ps

// Rounded square root of an unsigned 64-bit value, saturated to 32 bits,
// shifted right by the shift_amount register (APB offset 0). A request is
// taken in every cycle (busy stays low) and its result appears on root_o and
// last_out_o with done_o high for one cycle, once it has passed through 32
// registered digit stages of the root recurrence, one rounding stage and one
// shift/output stage. Results come back in request order and the receiver
// cannot stall them. Write shift_amount only when no request is in flight.
module rounded_sqrt_u64_shift (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [rsq_pkg::ValueW-1:0] value_i,
  input  logic                       last_in_i,
  output logic                       done_o,
  output logic [rsq_pkg::RootW-1:0]  root_o,
  output logic                       last_out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import rsq_pkg::*;

  logic [ShiftW-1:0] shift_q;
  logic              stg_vld [0:NumSteps];
  rsq_stage_t        stg_d   [0:NumSteps];
  logic              narrow_op;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegShiftAmount) ? {{(32-ShiftW){1'b0}}, shift_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegShiftAmount) begin
      shift_q <= pwdata[ShiftW-1:0];
    end
  end

  assign busy = 1'b0;

  assign narrow_op  = (value_i[ValueW-1:RootW] == '0);
  assign stg_vld[0] = start && !busy;
  // fields in struct order: rad, rem, root, narrow, last
  assign stg_d[0]   = {value_i, {RemW{1'b0}}, {RootW{1'b0}}, narrow_op, last_in_i};

  for (genvar i = 0; i < NumSteps; i++) begin : g_step
    rsq_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (stg_vld[i]),
      .d_i    (stg_d[i]),
      .vld_o  (stg_vld[i+1]),
      .q_o    (stg_d[i+1])
    );
  end

  rsq_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (stg_vld[NumSteps]),
    .d_i     (stg_d[NumSteps]),
    .shift_i (shift_q),
    .done_o  (done_o),
    .root_o  (root_o),
    .last_o  (last_out_o)
  );

endmodule

// ===== rtl/rsq_check.sv =====
// rsq_check: port-level checks for rounded_sqrt_u64_shift, bound to the top.
// Depends on rsq_pkg for the pipeline latency.
`timescale 1ns / 1ps

module rsq_check (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic [rsq_pkg::ValueW-1:0] value_i,
  input logic                       last_in_i,
  input logic                       done_o,
  input logic [rsq_pkg::RootW-1:0]  root_o,
  input logic                       last_out_o
);
  import rsq_pkg::*;

  // cycles since reset, saturating once the pipeline has fully refilled
  logic [5:0] age_q;
  logic       warm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q <= '0;
    end else if (!warm) begin
      age_q <= age_q + 6'd1;
    end
  end

  assign warm = (age_q >= 6'(Latency));

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_request_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency done_o)
    else $error("request produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && done_o) |-> $past(start && !busy, Latency))
    else $error("result without request");

  a_last_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && done_o) |-> last_out_o == $past(last_in_i, Latency))
    else $error("last marker mismatch");

  a_zero_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && value_i == '0) |-> ##Latency (root_o == '0))
    else $error("zero operand gave nonzero root");

endmodule

bind rounded_sqrt_u64_shift rsq_check u_rsq_check (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .value_i    (value_i),
  .last_in_i  (last_in_i),
  .done_o     (done_o),
  .root_o     (root_o),
  .last_out_o (last_out_o)
);
